// ----- hdl/ctg_pkg.sv -----
// ----------------------------------------------------------------------------
// ctg_pkg
// shared types, codes and sizes for the tone generator core
// ----------------------------------------------------------------------------
package ctg_pkg;

	localparam int COUNTER_BITS = 16;
	localparam int TOP_BITS     = 16;
	localparam int CMP_BITS     = (COUNTER_BITS > TOP_BITS) ? COUNTER_BITS : TOP_BITS;
	localparam int CLOCK_BITS   = 27;
	localparam int FREQ_BITS    = 16;

	// clock_hz / (16 * f) == (clock_hz >> 4) / f
	localparam int PRESCALE_SHIFT = 4;
	localparam int DIVIDEND_BITS  = CLOCK_BITS - PRESCALE_SHIFT;
	localparam int DIV_STEPS      = DIVIDEND_BITS;
	localparam int DIV_CNT_BITS   = $clog2(DIV_STEPS);

	localparam logic [CLOCK_BITS-1:0] CLOCK_RESET = CLOCK_BITS'(16000000);
	localparam logic [TOP_BITS-1:0]   TOP_LIMIT   = TOP_BITS'(65535);

	localparam logic [1:0] KIND_TICK     = 2'd0;
	localparam logic [1:0] KIND_SET_TONE = 2'd1;
	localparam logic [1:0] KIND_OFF      = 2'd2;
	localparam logic [1:0] KIND_ON       = 2'd3;

	typedef struct packed {
		logic [1:0]           kind;
		logic [FREQ_BITS-1:0] frequency;
	} src_word_t;

	typedef struct packed {
		logic                pin_level;
		logic [TOP_BITS-1:0] compare_top;
		logic                output_connected;
	} res_word_t;

	typedef struct packed {
		logic apply;
		logic step;
		logic commit;
	} ctg_cmd_t;

	typedef struct packed {
		logic need_div;
	} ctg_sts_t;

endpackage

// ----- hdl/ctg_ctrl.sv -----
// ----------------------------------------------------------------------------
// ctg_ctrl
// sequencer: input handshake, divider step count and result valid
// ----------------------------------------------------------------------------
module ctg_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              src_valid,
	output logic              src_stall,
	output logic              res_valid,
	input  logic              res_stall,
	input  ctg_pkg::ctg_sts_t sts,
	output ctg_pkg::ctg_cmd_t cmd
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_DIV    = 2'd1;
	localparam logic [1:0] ST_COMMIT = 2'd2;

	logic [1:0]                       state_q;
	logic [ctg_pkg::DIV_CNT_BITS-1:0] cnt_q;
	logic                             res_valid_q;
	logic                             accept;
	logic                             res_set;

	assign src_stall = (state_q != ST_IDLE) || (res_valid_q && res_stall);
	assign accept    = src_valid && !src_stall;
	assign res_valid = res_valid_q;
	assign res_set   = (accept && !sts.need_div) || (state_q == ST_COMMIT);

	always_comb begin
		cmd        = '0;
		cmd.apply  = accept;
		cmd.step   = (state_q == ST_DIV);
		cmd.commit = (state_q == ST_COMMIT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_set)
				res_valid_q <= 1'b1;
			else if (!res_stall)
				res_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept && sts.need_div) begin
						state_q <= ST_DIV;
						cnt_q   <= '0;
					end
				end
				ST_DIV: begin
					if (cnt_q == ctg_pkg::DIV_CNT_BITS'(ctg_pkg::DIV_STEPS - 1))
						state_q <= ST_COMMIT;
					cnt_q <= cnt_q + 1'b1;
				end
				ST_COMMIT: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- hdl/ctg_datapath.sv -----
// ----------------------------------------------------------------------------
// ctg_datapath
// timer state, toggle flip-flop, clock register and restoring divider
// ----------------------------------------------------------------------------
module ctg_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [ctg_pkg::CLOCK_BITS-1:0]    cfg_data,
	input  ctg_pkg::src_word_t                src_word,
	output ctg_pkg::res_word_t                res_word,
	input  ctg_pkg::ctg_cmd_t                 cmd,
	output ctg_pkg::ctg_sts_t                 sts
);

	logic [ctg_pkg::CLOCK_BITS-1:0]    clock_hz_q;
	logic [ctg_pkg::COUNTER_BITS-1:0]  tick_counter_q;
	logic [ctg_pkg::TOP_BITS-1:0]      top_q;
	logic                              connected_q;
	logic                              toggle_q;

	logic [ctg_pkg::DIVIDEND_BITS-1:0] dq_q;
	logic [ctg_pkg::FREQ_BITS-1:0]     rem_q;
	logic [ctg_pkg::FREQ_BITS-1:0]     divisor_q;

	logic [ctg_pkg::FREQ_BITS:0]       trial;
	logic                              trial_ge;
	logic                              at_top;
	logic [ctg_pkg::TOP_BITS-1:0]      new_top;

	assign sts.need_div = (src_word.kind == ctg_pkg::KIND_SET_TONE) &&
		(src_word.frequency != '0);

	assign trial    = {rem_q, dq_q[ctg_pkg::DIVIDEND_BITS-1]};
	assign trial_ge = trial >= {1'b0, divisor_q};

	assign at_top = ctg_pkg::CMP_BITS'(tick_counter_q) == ctg_pkg::CMP_BITS'(top_q);

	// zero quotient wraps, large quotient saturates
	always_comb begin
		if (dq_q == '0 ||
			dq_q > ctg_pkg::DIVIDEND_BITS'({1'b0, ctg_pkg::TOP_LIMIT} + 17'd1))
			new_top = ctg_pkg::TOP_LIMIT;
		else
			new_top = ctg_pkg::TOP_BITS'(dq_q - 1'b1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_hz_q     <= ctg_pkg::CLOCK_RESET;
			tick_counter_q <= '0;
			top_q          <= '0;
			connected_q    <= 1'b1;
			toggle_q       <= 1'b0;
		end else begin
			if (cfg_we)
				clock_hz_q <= cfg_data;
			if (cmd.apply) begin
				case (src_word.kind)
					ctg_pkg::KIND_TICK: begin
						if (at_top) begin
							tick_counter_q <= '0;
							toggle_q       <= !toggle_q;
						end else begin
							tick_counter_q <= tick_counter_q + 1'b1;
						end
					end
					ctg_pkg::KIND_SET_TONE: begin
						if (src_word.frequency == '0)
							connected_q <= 1'b0;
					end
					ctg_pkg::KIND_OFF: begin
						connected_q <= 1'b0;
					end
					default: begin
						connected_q <= 1'b1;
					end
				endcase
			end
			if (cmd.commit)
				top_q <= new_top;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			dq_q      <= clock_hz_q[ctg_pkg::CLOCK_BITS-1:ctg_pkg::PRESCALE_SHIFT];
			rem_q     <= '0;
			divisor_q <= src_word.frequency;
		end else if (cmd.step) begin
			if (trial_ge)
				rem_q <= ctg_pkg::FREQ_BITS'(trial - {1'b0, divisor_q});
			else
				rem_q <= trial[ctg_pkg::FREQ_BITS-1:0];
			dq_q <= {dq_q[ctg_pkg::DIVIDEND_BITS-2:0], trial_ge};
		end
	end

	assign res_word.pin_level        = connected_q && toggle_q;
	assign res_word.compare_top      = top_q;
	assign res_word.output_connected = connected_q;

endmodule

// ----- hdl/ctc_tone_generator_core.sv -----
// ----------------------------------------------------------------------------
// ctc_tone_generator_core
// square-wave tone generator on a clear-on-compare timer with toggle output
//
//   channel  signals                       word
//   source   src_valid src_stall src_word  kind, frequency
//   result   res_valid res_stall res_word  pin_level, compare_top, output_connected
//   config   cfg_we cfg_data               clock_hz
//
// tick, off, enable and zero-frequency words: result valid next cycle
// set-tone word: top set by the 23-step one-bit-per-cycle restoring divider, then committed
// reset: clock_hz 16000000, counter and top 0, output connected, toggle low
// the state registers are the result word, so a stalled result holds them
// src_stall is high while the divider runs or commits, or while a result waits under stall
// ----------------------------------------------------------------------------
module ctc_tone_generator_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           src_valid,
	output logic                           src_stall,
	input  ctg_pkg::src_word_t             src_word,
	output logic                           res_valid,
	input  logic                           res_stall,
	output ctg_pkg::res_word_t             res_word,
	input  logic                           cfg_we,
	input  logic [ctg_pkg::CLOCK_BITS-1:0] cfg_data
);

	ctg_pkg::ctg_cmd_t cmd;
	ctg_pkg::ctg_sts_t sts;

	ctg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	ctg_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.src_word (src_word),
		.res_word (res_word),
		.cmd      (cmd),
		.sts      (sts)
	);

	a_quick_result: assert property (@(posedge clk) disable iff (!arst_n)
		(src_valid && !src_stall && src_word.kind != ctg_pkg::KIND_SET_TONE) |=> res_valid)
		else $error("result missing after single-cycle word");

	a_div_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(src_valid && !src_stall && sts.need_div) |=> (src_stall && !res_valid))
		else $error("divider not busy after set-tone word");

	a_pin_gated: assert property (@(posedge clk) disable iff (!arst_n)
		res_word.pin_level |-> res_word.output_connected)
		else $error("pin driven while disconnected");

endmodule
